@@ design/plec_pkg.sv @@
// ----------------------------------------------------------------------------
// plec_pkg - shared types and constants for the piecewise-linear error
// correction unit
//
// Field types, region codes, register indexes and pipeline geometry.
// ----------------------------------------------------------------------------
package plec_pkg;

   // Field types
   typedef logic signed [31:0] meas_type;
   typedef logic [1:0]         region_type;
   typedef logic [30:0]        fs_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [63:0]        csr_data_type;

   // Table geometry
   localparam int NumPoints = 10;
   localparam int NumPairs  = NumPoints / 2;
   localparam int FracBits  = 16;
   localparam int SegBits   = 4;
   localparam int QuoBits   = SegBits + FracBits;

   // Region codes
   localparam region_type RegionPass   = 2'd0;
   localparam region_type RegionInterp = 2'd1;
   localparam region_type RegionFull   = 2'd2;

   // Register indexes
   localparam csr_index_type CsrCalValid  = 3'd0;
   localparam csr_index_type CsrFullScale = 3'd1;
   localparam csr_index_type CsrPair0     = 3'd2;
   localparam csr_index_type CsrPair1     = 3'd3;
   localparam csr_index_type CsrPair2     = 3'd4;
   localparam csr_index_type CsrPair3     = 3'd5;
   localparam csr_index_type CsrPair4     = 3'd6;

   // Pipeline geometry: decode, divider stages, lookup, multiply, add, output
   localparam int DivStepsPerStage = 2;
   localparam int DivStages        = QuoBits / DivStepsPerStage;
   localparam int LkStage          = DivStages + 1;
   localparam int MulStage         = DivStages + 2;
   localparam int AddStage         = DivStages + 3;
   localparam int OutStage         = DivStages + 4;
   localparam int NumStages        = OutStage + 1;

   // Saturation limits
   localparam meas_type MeasMax = 32'sh7fff_ffff;
   localparam meas_type MeasMin = 32'sh8000_0000;

   // Restoring divider state: partial remainder and dividend/quotient shifter
   typedef struct packed {
      logic [30:0]        rem;
      logic [QuoBits-1:0] dq;
   } div_state_type;

endpackage

@@ design/plec_if.sv @@
// ----------------------------------------------------------------------------
// plec_if - channel interfaces of the piecewise-linear error correction unit
//
// Measurement request, corrected response and register write channels.
// ----------------------------------------------------------------------------

// Measurement request channel
interface plec_req_if;
   import plec_pkg::*;
   logic     valid;
   logic     ready;
   meas_type measured;
   modport source (output valid, output measured, input ready);
   modport sink (input valid, input measured, output ready);
endinterface

// Corrected response channel
interface plec_rsp_if;
   import plec_pkg::*;
   logic       valid;
   logic       ready;
   meas_type   corrected;
   region_type region;
   logic       saturated;
   modport source (output valid, output corrected, output region, output saturated,
                   input ready);
   modport sink (input valid, input corrected, input region, input saturated,
                 output ready);
endinterface

// Register write channel
interface plec_csr_if;
   import plec_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/piecewise_linear_error_correction_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_error_correction_unit - calibration error correction
//
// Throughput: one transaction per cycle unless the response channel stalls;
// the 20-bit restoring divider is unrolled two quotient bits per stage over
// ten stages.
// Reset: clears pipeline valid bits and all configuration registers (correction disabled).
// ----------------------------------------------------------------------------
module piecewise_linear_error_correction_unit (
   input logic        clock,
   input logic        reset,
   plec_req_if.sink   req_if,
   plec_rsp_if.source rsp_if,
   plec_csr_if.sink   csr_if
);
   import plec_pkg::*;

   // Configuration registers
   logic         cal_valid_ff;
   fs_type       full_scale_ff;
   csr_data_type error_pair_ff [NumPairs];

   // Pipeline control
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages-1:0] stg_ready;

   // Payload travelling with each transaction
   meas_type      meas_ff   [0:AddStage];
   region_type    region_ff [0:AddStage];
   div_state_type div_ff    [0:DivStages];
   div_state_type div_in    [1:DivStages];

   // Decode stage inputs
   logic          pass_in;
   logic          full_in;
   region_type    region_in;
   logic [34:0]   scaled_in;
   div_state_type div0_in;

   // Lookup stage
   logic [SegBits-1:0]  seg_raw;
   logic [SegBits-1:0]  seg;
   meas_type            lk_e0_in;
   meas_type            lk_e1;
   logic signed [32:0]  lk_diff_in;
   meas_type            lk_e0_ff;
   logic signed [32:0]  lk_diff_ff;
   logic [FracBits-1:0] lk_t_ff;

   // Multiply stage
   logic signed [49:0] mul_prod_in;
   logic signed [49:0] mul_prod_ff;
   meas_type           mul_e0_ff;

   // Add stage
   logic signed [49:0] add_shift;
   logic signed [33:0] add_err_in;
   logic signed [33:0] add_err_ff;

   // Output stage
   logic signed [34:0] out_diff;
   meas_type           out_corr_in;
   logic               out_sat_in;
   meas_type           out_corr_ff;
   region_type         out_region_ff;
   logic               out_sat_ff;

   // Error at table point p (1..10)
   function automatic meas_type err_point(logic [SegBits-1:0] p);
      logic [SegBits-1:0] idx;
      csr_data_type       pair;
      idx  = p - SegBits'(1);
      pair = error_pair_ff[idx[SegBits-1:1]];
      return idx[0] ? pair[63:32] : pair[31:0];
   endfunction

   // One restoring division step
   function automatic div_state_type div_step(div_state_type cur, fs_type fs);
      logic [31:0]   trial;
      logic [31:0]   sub;
      div_state_type nxt;
      trial = {cur.rem, cur.dq[QuoBits-1]};
      sub   = trial - {1'b0, fs};
      if (trial >= {1'b0, fs}) begin
         nxt.rem = sub[30:0];
         nxt.dq  = {cur.dq[QuoBits-2:0], 1'b1};
      end else begin
         nxt.rem = trial[30:0];
         nxt.dq  = {cur.dq[QuoBits-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Register writes; always ready
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_valid_ff  <= 1'b0;
         full_scale_ff <= '0;
         for (int i = 0; i < NumPairs; i++) begin
            error_pair_ff[i] <= '0;
         end
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CsrCalValid:  cal_valid_ff     <= csr_if.data[0];
            CsrFullScale: full_scale_ff    <= csr_if.data[30:0];
            CsrPair0:     error_pair_ff[0] <= csr_if.data;
            CsrPair1:     error_pair_ff[1] <= csr_if.data;
            CsrPair2:     error_pair_ff[2] <= csr_if.data;
            CsrPair3:     error_pair_ff[3] <= csr_if.data;
            CsrPair4:     error_pair_ff[4] <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when empty or when its successor loads
   always_comb begin
      stg_ready[NumStages-1] = !vld_ff[NumStages-1] || rsp_if.ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         stg_ready[i] = !vld_ff[i] || stg_ready[i+1];
      end
      vld_in[0] = req_if.valid;
      for (int i = 1; i < NumStages; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_if.ready = stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NumStages; i++) begin
            if (stg_ready[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Decode: classify, scale by ten, seed the divider
   always_comb begin
      pass_in   = !cal_valid_ff || (full_scale_ff == '0) ||
                  req_if.measured[31] || (req_if.measured == '0);
      full_in   = req_if.measured[30:0] >= full_scale_ff;
      region_in = pass_in ? RegionPass : (full_in ? RegionFull : RegionInterp);
      scaled_in = {1'b0, req_if.measured[30:0], 3'b000} +
                  {3'b000, req_if.measured[30:0], 1'b0};
      div0_in.rem = scaled_in[34:4];
      div0_in.dq  = {scaled_in[3:0], {FracBits{1'b0}}};
   end

   // Divider stages: segment index and fraction of 10*m/fs
   always_comb begin
      div_state_type cur;
      for (int j = 1; j <= DivStages; j++) begin
         cur = div_ff[j-1];
         for (int s = 0; s < DivStepsPerStage; s++) begin
            cur = div_step(cur, full_scale_ff);
         end
         div_in[j] = cur;
      end
   end

   // Lookup: end points of the segment, or the last point at full scale
   always_comb begin
      seg_raw = div_ff[DivStages].dq[QuoBits-1 -: SegBits];
      seg     = (seg_raw > SegBits'(NumPoints - 1)) ? SegBits'(NumPoints - 1) : seg_raw;
      lk_e1   = err_point(seg + SegBits'(1));
      if (region_ff[DivStages] == RegionFull) begin
         lk_e0_in   = err_point(SegBits'(NumPoints));
         lk_diff_in = '0;
      end else begin
         lk_e0_in   = (seg == '0) ? '0 : err_point(seg);
         lk_diff_in = 33'(lk_e1) - 33'(lk_e0_in);
      end
   end

   // Multiply slope by fraction, then floor and add the base error
   assign mul_prod_in = lk_diff_ff * $signed({1'b0, lk_t_ff});
   assign add_shift   = mul_prod_ff >>> FracBits;
   assign add_err_in  = 34'(mul_e0_ff) + add_shift[33:0];

   // Subtract and saturate; pass-region transactions bypass both
   always_comb begin
      out_diff    = 35'(meas_ff[AddStage]) - 35'(add_err_ff);
      out_corr_in = out_diff[31:0];
      out_sat_in  = 1'b0;
      if (!out_diff[34] && (out_diff[33:31] != 3'b000)) begin
         out_corr_in = MeasMax;
         out_sat_in  = 1'b1;
      end else if (out_diff[34] && (out_diff[33:31] != 3'b111)) begin
         out_corr_in = MeasMin;
         out_sat_in  = 1'b1;
      end
      if (region_ff[AddStage] == RegionPass) begin
         out_corr_in = meas_ff[AddStage];
         out_sat_in  = 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         meas_ff[0]   <= req_if.measured;
         region_ff[0] <= region_in;
         div_ff[0]    <= div0_in;
      end
      for (int i = 1; i <= AddStage; i++) begin
         if (stg_ready[i]) begin
            meas_ff[i]   <= meas_ff[i-1];
            region_ff[i] <= region_ff[i-1];
         end
      end
      for (int j = 1; j <= DivStages; j++) begin
         if (stg_ready[j]) begin
            div_ff[j] <= div_in[j];
         end
      end
      if (stg_ready[LkStage]) begin
         lk_e0_ff   <= lk_e0_in;
         lk_diff_ff <= lk_diff_in;
         lk_t_ff    <= div_ff[DivStages].dq[FracBits-1:0];
      end
      if (stg_ready[MulStage]) begin
         mul_prod_ff <= mul_prod_in;
         mul_e0_ff   <= lk_e0_ff;
      end
      if (stg_ready[AddStage]) begin
         add_err_ff <= add_err_in;
      end
      if (stg_ready[OutStage]) begin
         out_corr_ff   <= out_corr_in;
         out_region_ff <= region_ff[AddStage];
         out_sat_ff    <= out_sat_in;
      end
   end

   // Response channel
   assign rsp_if.valid     = vld_ff[OutStage];
   assign rsp_if.corrected = out_corr_ff;
   assign rsp_if.region    = out_region_ff;
   assign rsp_if.saturated = out_sat_ff;

   // Assertions
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("accepted transaction did not enter decode stage");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivStages] && (region_ff[DivStages] == RegionInterp) |->
      (div_ff[DivStages].rem < full_scale_ff) &&
      (div_ff[DivStages].dq[QuoBits-1 -: SegBits] <= SegBits'(NumPoints - 1)))
      else $error("divider remainder or segment index out of range");

   a_pass_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.region == RegionPass) |-> !rsp_if.saturated)
      else $error("pass-through transaction flagged as saturated");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturated |->
      (rsp_if.corrected == MeasMax) || (rsp_if.corrected == MeasMin))
      else $error("saturated result is not a limit value");

endmodule
